/* hw/rtl/bboq_pkg.sv */
// Package for the bounding volume hierarchy box query block.
// Holds sizes, operation codes, node record layout and controller types.
// No dependencies.
package bboq_pkg;

  localparam int MAX_NODES   = 128;
  localparam int STACK_DEPTH = 32;
  localparam int RESULT_CAP  = 64;

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int STK_W  = $clog2(STACK_DEPTH);
  localparam int TOP_W  = $clog2(STACK_DEPTH + 1);
  localparam int POPS_W = $clog2(MAX_NODES + 1);
  localparam int CNT_W  = $clog2(RESULT_CAP + 1);

  localparam int COORD_W = 32;
  localparam int LINK_W  = 8;
  localparam int TAG_W   = 32;
  localparam int IN_W    = 248;

  localparam logic             OP_WRITE = 1'b0;
  localparam logic             OP_QUERY = 1'b1;
  localparam logic [LINK_W-1:0] NO_LINK = 8'hFF;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [LINK_W-1:0]  left;
    logic [LINK_W-1:0]  right;
    logic [COORD_W-1:0] hi_x;
    logic [COORD_W-1:0] hi_y;
    logic [COORD_W-1:0] hi_z;
    logic [COORD_W-1:0] lo_x;
    logic [COORD_W-1:0] lo_y;
    logic [COORD_W-1:0] lo_z;
  } node_t;

  typedef struct packed {
    logic [COORD_W-1:0] lo_x;
    logic [COORD_W-1:0] lo_y;
    logic [COORD_W-1:0] lo_z;
    logic [COORD_W-1:0] hi_x;
    logic [COORD_W-1:0] hi_y;
    logic [COORD_W-1:0] hi_z;
  } qbox_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_STK,
    ST_NODE,
    ST_PUSHL,
    ST_PUSHR,
    ST_FLUSH
  } bboq_state_t;

  typedef struct packed {
    logic wr_node;
    logic start;
    logic pop;
    logic node_rd;
    logic push_l;
    logic push_r;
    logic take_leaf;
    logic set_ovf;
    logic flush;
  } bboq_cmd_t;

  typedef struct packed {
    logic top_zero;
    logic top_full;
    logic pops_done;
    logic cap_next;
    logic is_leaf;
    logic overlap;
    logic left_ok;
    logic right_ok;
    logic pend_valid;
    logic out_full;
  } bboq_status_t;

  function automatic logic link_ok(logic [LINK_W-1:0] l);
    int v;
    v = int'($signed(l));
    return (v >= 0) && (v < MAX_NODES);
  endfunction

endpackage

/* hw/rtl/bboq_datapath.sv */
// Datapath of the box query block: node memory, walk stack, counters,
// overlap test, pending result and output register.
// Depends on bboq_pkg; driven by bboq_ctrl.
module bboq_datapath import bboq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bboq_cmd_t            cmd,
  output bboq_status_t         sts,
  input  logic [IN_W-1:0]      in_tdata,
  input  logic                 cfg_wr_en,
  input  logic [NODE_W-1:0]    cfg_wr_data,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [TAG_W-1:0]     out_tdata,
  output logic [1:0]           out_tuser,
  output logic                 out_tlast
);

  node_t                 node_mem [MAX_NODES];
  logic [NODE_W-1:0]     stack_mem [STACK_DEPTH];

  logic [NODE_W-1:0]     root_r;
  qbox_t                 qbox_r;
  logic [TOP_W-1:0]      top_r, top_nxt;
  logic [POPS_W-1:0]     pops_r, pops_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  pend_valid_r, pend_valid_nxt;
  logic [TAG_W-1:0]      pend_tag_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [TAG_W-1:0]      out_tag_r;
  logic                  out_hit_r, out_ovf_r, out_last_r;
  logic [NODE_W-1:0]     stk_q_r;
  node_t                 node_q_r;

  logic [NODE_W-1:0]     in_index;
  node_t                 in_node;
  qbox_t                 in_box;
  logic [TOP_W-1:0]      top_dec;
  logic                  stk_we;
  logic [STK_W-1:0]      stk_waddr;
  logic [NODE_W-1:0]     stk_wdata;
  logic                  ov_x, ov_y, ov_z;

  assign in_index      = in_tdata[6:0];
  assign in_box.lo_x   = in_tdata[38:7];
  assign in_box.lo_y   = in_tdata[70:39];
  assign in_box.lo_z   = in_tdata[102:71];
  assign in_box.hi_x   = in_tdata[134:103];
  assign in_box.hi_y   = in_tdata[166:135];
  assign in_box.hi_z   = in_tdata[198:167];
  assign in_node.left  = in_tdata[206:199];
  assign in_node.right = in_tdata[214:207];
  assign in_node.tag   = in_tdata[246:215];
  assign in_node.lo_x  = in_box.lo_x;
  assign in_node.lo_y  = in_box.lo_y;
  assign in_node.lo_z  = in_box.lo_z;
  assign in_node.hi_x  = in_box.hi_x;
  assign in_node.hi_y  = in_box.hi_y;
  assign in_node.hi_z  = in_box.hi_z;

  assign top_dec = top_r - 1'b1;

  // node memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_node) begin
      node_mem[in_index] <= in_node;
    end
    if (cmd.node_rd) begin
      node_q_r <= node_mem[stk_q_r];
    end
  end

  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = top_r[STK_W-1:0];
    stk_wdata = root_r;
    if (cmd.start) begin
      stk_we    = 1'b1;
      stk_waddr = '0;
    end else if (cmd.push_l) begin
      stk_we    = 1'b1;
      stk_wdata = node_q_r.left[NODE_W-1:0];
    end else if (cmd.push_r) begin
      stk_we    = 1'b1;
      stk_wdata = node_q_r.right[NODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    if (cmd.pop) begin
      stk_q_r <= stack_mem[top_dec[STK_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
    end else if (cfg_wr_en) begin
      root_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qbox_r <= in_box;
    end
  end

  always_comb begin
    top_nxt        = top_r;
    pops_nxt       = pops_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    pend_valid_nxt = pend_valid_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    if (cmd.start) begin
      top_nxt        = TOP_W'(1);
      pops_nxt       = '0;
      count_nxt      = '0;
      ovf_nxt        = 1'b0;
      pend_valid_nxt = 1'b0;
    end
    if (cmd.pop) begin
      top_nxt  = top_dec;
      pops_nxt = pops_r + 1'b1;
    end
    if (cmd.push_l || cmd.push_r) begin
      top_nxt = top_r + 1'b1;
    end
    if (cmd.set_ovf) begin
      ovf_nxt = 1'b1;
    end
    if (cmd.take_leaf) begin
      count_nxt      = count_r + 1'b1;
      pend_valid_nxt = 1'b1;
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
      end
    end
    if (cmd.flush) begin
      pend_valid_nxt = 1'b0;
      out_valid_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r        <= '0;
      pops_r       <= '0;
      count_r      <= '0;
      ovf_r        <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      top_r        <= top_nxt;
      pops_r       <= pops_nxt;
      count_r      <= count_nxt;
      ovf_r        <= ovf_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_leaf) begin
      pend_tag_r <= node_q_r.tag;
      if (pend_valid_r) begin
        out_tag_r  <= pend_tag_r;
        out_hit_r  <= 1'b1;
        out_ovf_r  <= 1'b0;
        out_last_r <= 1'b0;
      end
    end else if (cmd.flush) begin
      out_tag_r  <= pend_valid_r ? pend_tag_r : '0;
      out_hit_r  <= pend_valid_r;
      out_ovf_r  <= ovf_r;
      out_last_r <= 1'b1;
    end
  end

  assign ov_x = ($signed(qbox_r.lo_x) <= $signed(node_q_r.hi_x)) &&
                ($signed(node_q_r.lo_x) <= $signed(qbox_r.hi_x));
  assign ov_y = ($signed(qbox_r.lo_y) <= $signed(node_q_r.hi_y)) &&
                ($signed(node_q_r.lo_y) <= $signed(qbox_r.hi_y));
  assign ov_z = ($signed(qbox_r.lo_z) <= $signed(node_q_r.hi_z)) &&
                ($signed(node_q_r.lo_z) <= $signed(qbox_r.hi_z));

  assign sts.top_zero   = (top_r == '0);
  assign sts.top_full   = (top_r == TOP_W'(STACK_DEPTH));
  assign sts.pops_done  = (pops_r == POPS_W'(MAX_NODES));
  assign sts.cap_next   = (count_r == CNT_W'(RESULT_CAP - 1));
  assign sts.is_leaf    = (node_q_r.left == NO_LINK) && (node_q_r.right == NO_LINK);
  assign sts.overlap    = ov_x && ov_y && ov_z;
  assign sts.left_ok    = link_ok(node_q_r.left);
  assign sts.right_ok   = link_ok(node_q_r.right);
  assign sts.pend_valid = pend_valid_r;
  assign sts.out_full   = out_valid_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tag_r;
  assign out_tuser  = {out_ovf_r, out_hit_r};
  assign out_tlast  = out_last_r;

endmodule

/* hw/rtl/bboq_ctrl.sv */
// Walk controller of the box query block: sequences pops, node reads,
// pushes and result hand-off through command and status structs.
// Depends on bboq_pkg; drives bboq_datapath.
module bboq_ctrl import bboq_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_op,
  output logic         in_tready,
  input  bboq_status_t sts,
  output bboq_cmd_t    cmd
);

  bboq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && (in_op == OP_QUERY)) begin
          state_nxt = ST_POP;
        end
      end
      ST_POP: begin
        if (sts.top_zero || sts.pops_done) begin
          state_nxt = ST_FLUSH;
        end else begin
          state_nxt = ST_STK;
        end
      end
      ST_STK: state_nxt = ST_NODE;
      ST_NODE: begin
        if (sts.is_leaf) begin
          if (!(sts.pend_valid && sts.out_full)) begin
            state_nxt = sts.cap_next ? ST_FLUSH : ST_POP;
          end
        end else if (sts.overlap) begin
          state_nxt = ST_PUSHL;
        end else begin
          state_nxt = ST_POP;
        end
      end
      ST_PUSHL: begin
        state_nxt = (sts.left_ok && sts.top_full) ? ST_FLUSH : ST_PUSHR;
      end
      ST_PUSHR: begin
        state_nxt = (sts.right_ok && sts.top_full) ? ST_FLUSH : ST_POP;
      end
      ST_FLUSH: begin
        if (!sts.out_full) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.wr_node = in_tvalid && (in_op == OP_WRITE);
        cmd.start   = in_tvalid && (in_op == OP_QUERY);
      end
      ST_POP: begin
        cmd.set_ovf = !sts.top_zero && sts.pops_done;
        cmd.pop     = !sts.top_zero && !sts.pops_done;
      end
      ST_STK: cmd.node_rd = 1'b1;
      ST_NODE: begin
        cmd.take_leaf = sts.is_leaf && !(sts.pend_valid && sts.out_full);
      end
      ST_PUSHL: begin
        cmd.push_l  = sts.left_ok && !sts.top_full;
        cmd.set_ovf = sts.left_ok && sts.top_full;
      end
      ST_PUSHR: begin
        cmd.push_r  = sts.right_ok && !sts.top_full;
        cmd.set_ovf = sts.right_ok && sts.top_full;
      end
      ST_FLUSH: cmd.flush = !sts.out_full;
      default: cmd = '0;
    endcase
  end

endmodule

/* hw/rtl/bvh_box_overlap_query.sv */
// Write request: taken while idle; node memory is written at the edge that takes it.
// Query request: start, then per popped node a pop, a node memory read and a decide step;
// an overlapping inner node adds a push-left and a push-right step; an empty stack leads
// to the flush step, which hands off the final result once the output register is free;
// a leaf waits while two results are held. At most 128 pops. One request at a time.
// Synchronous active-low reset clears control state; node memory is not cleared.
module bvh_box_overlap_query import bboq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // node_index, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, left_child, right_child,
  // leaf_tag, zero pad
  input  logic [IN_W-1:0]   in_tdata,
  // op
  input  logic              in_tuser,
  input  logic              cfg_wr_en,
  // root_index
  input  logic [NODE_W-1:0] cfg_wr_data,
  output logic              out_tvalid,
  input  logic              out_tready,
  // found_tag
  output logic [TAG_W-1:0]  out_tdata,
  // hit, overflow
  output logic [1:0]        out_tuser,
  output logic              out_tlast
);

  bboq_cmd_t    cmd;
  bboq_status_t sts;

  bboq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bboq_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

/* hw/rtl/bboq_checker.sv */
// Port-level checks for the box query block, bound to the top level.
// Depends on bboq_pkg.
module bboq_checker import bboq_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [TAG_W-1:0]  out_tdata,
  input logic [1:0]        out_tuser,
  input logic              out_tlast
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast && (out_tdata == '0))
    else $error("empty marker not final or tag not zero");

  a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("overflow flag on non-final result");

endmodule

bind bvh_box_overlap_query bboq_checker u_chk (.*);
